// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the hasher.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha checker: same-cycle rule violated");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SHA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha checker: next-cycle rule violated");

`endif

// ----- sv/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 hasher.
// Used by sha_core and sha256_message_hasher_top; depends on nothing.
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] hash_type;

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [5:0] LenPos   = 6'd56;
   localparam logic [5:0] LastRnd  = 6'd63;
   localparam logic [1:0] LastWord = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_ADD,
      ST_OUT
   } sha_state_type;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic       shift_en;
      logic [7:0] byte_val;
      logic       load;
      logic       round;
      logic [5:0] rnd;
      logic       update;
      logic       restart;
   } sha_ctl_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type v;
      unique case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic word_type k_const(input logic [5:0] idx);
      word_type v;
      unique case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
      endcase
      return v;
   endfunction

endpackage

// ----- sv/sha_core.sv -----
// SHA-256 round unit: 512-bit block/schedule window, working variables, chaining words.
// Depends on sha_pkg; driven one step per cycle by the sequencer in the top level.
module sha_core (
   input  logic                 clock,
   input  logic                 reset,
   input  sha_pkg::sha_ctl_type ctl,
   output sha_pkg::hash_type    hash
);
   import sha_pkg::*;

   logic [511:0] win_ff, win_in;
   hash_type     work_ff, work_in;
   hash_type     hash_ff, hash_in;
   word_type     w_cur, w_new, t1, t2, ch, maj;

   // Word j of the window is W[t + j]; word 0 sits in the top bits.
   assign w_cur = win_ff[511:480];
   assign w_new = small_sigma1(win_ff[63:32]) + win_ff[223:192]
                + small_sigma0(win_ff[479:448]) + win_ff[511:480];

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + big_sigma1(work_ff[4]) + ch + k_const(ctl.rnd) + w_cur;
   assign t2  = big_sigma0(work_ff[0]) + maj;

   always_comb begin
      win_in  = win_ff;
      work_in = work_ff;
      hash_in = hash_ff;
      if (ctl.shift_en) begin
         win_in = {win_ff[503:0], ctl.byte_val};
      end else if (ctl.round) begin
         win_in = {win_ff[479:0], w_new};
      end
      if (ctl.load) begin
         work_in = hash_ff;
      end else if (ctl.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (ctl.restart) begin
         for (int i = 0; i < 8; i++) hash_in[i] = iv_word(3'(i));
      end else if (ctl.update) begin
         for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + work_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= iv_word(3'(i));
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ----- sv/sha256_message_hasher_top.sv -----
// SHA-256 message hasher: takes one message byte per item, gives the digest as four words.
// Flow: a byte is taken whenever ready is high; every 64th byte holds ready low while the
// block is compressed on the shared round unit (the rounds, then the chaining add).
// End item: 9 to 72 padding bytes, one or two compressions, then four result words.
// Reset is synchronous: chaining words to the initial hash, count cleared, output empty.
// Depends on sha_pkg and sha_core.
module sha256_message_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   sha_state_type state_ff, state_in, ret_ff, ret_in;
   logic [63:0]   count_ff, count_in, len_ff, len_in;
   logic          first_ff, first_in, lenph_ff, lenph_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [1:0]    oidx_ff, oidx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_idx_ff, rsp_idx_in;
   logic          rsp_last_ff, rsp_last_in;

   sha_ctl_type   ctl;
   hash_type      hash;
   logic [63:0]   cnt_inc, len_shift;
   logic [7:0]    pad_byte;

   sha_core u_sha_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hash  (hash)
   );

   assign cnt_inc   = count_ff + 64'd1;
   assign len_shift = len_ff << {count_ff[2:0], 3'b000};
   assign pad_byte  = first_ff ? PadByte : (lenph_ff ? len_shift[63:56] : 8'h00);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      lenph_in     = lenph_ff;
      rnd_in       = rnd_ff;
      oidx_in      = oidx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      req_tready   = 1'b0;

      // drop the output word once taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            // ready is high here, so valid alone marks an accepted item
            if (req_tvalid) begin
               if (req_tuser) begin
                  ctl.shift_en = 1'b1;
                  ctl.byte_val = req_tdata;
                  count_in     = cnt_inc;
               end
               if (req_tlast) begin
                  len_in   = (req_tuser ? cnt_inc : count_ff) << 3;
                  first_in = 1'b1;
                  lenph_in = 1'b0;
               end
               if (req_tuser && cnt_inc[5:0] == 6'd0) begin
                  ctl.load = 1'b1;
                  rnd_in   = 6'd0;
                  state_in = ST_COMP;
                  ret_in   = req_tlast ? ST_PAD : ST_IDLE;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.shift_en = 1'b1;
            ctl.byte_val = pad_byte;
            count_in     = cnt_inc;
            first_in     = 1'b0;
            if (!lenph_ff && cnt_inc[5:0] == LenPos) lenph_in = 1'b1;
            if (cnt_inc[5:0] == 6'd0) begin
               ctl.load = 1'b1;
               rnd_in   = 6'd0;
               state_in = ST_COMP;
               ret_in   = lenph_ff ? ST_OUT : ST_PAD;
            end
         end
         ST_COMP: begin
            ctl.round = 1'b1;
            ctl.rnd   = rnd_ff;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == LastRnd) state_in = ST_ADD;
         end
         ST_ADD: begin
            ctl.update = 1'b1;
            oidx_in    = 2'd0;
            state_in   = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hash[{oidx_ff, 1'b0}], hash[{oidx_ff, 1'b1}]};
               rsp_idx_in   = oidx_ff;
               rsp_last_in  = (oidx_ff == LastWord);
               oidx_in      = oidx_ff + 2'd1;
               if (oidx_ff == LastWord) begin
                  ctl.restart = 1'b1;
                  count_in    = 64'd0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         count_ff     <= 64'd0;
         first_ff     <= 1'b0;
         lenph_ff     <= 1'b0;
         rnd_ff       <= 6'd0;
         oidx_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         lenph_ff     <= lenph_in;
         rnd_ff       <= rnd_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/sha_checker.sv -----
// Port-level checker for the SHA-256 hasher, attached to the top level by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sha_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // hold a stalled digest word
   `SHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // the final word is exactly the one with index three
   `SHA_ASSERT_IMP(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == 2'd3))

   // words of one digest follow back to back in index order
   `SHA_ASSERT_NXT(a_idx_seq, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tuser == 2'($past(rsp_tuser) + 2'd1))

   // padding starts right after the end item, so input stalls
   `SHA_ASSERT_NXT(a_end_stall, clock, reset, req_tvalid && req_tready && req_tlast,
      !req_tready)

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (.*);

// ----- test/testbench.sv -----
// Self-checking bench for sha256_message_hasher_top: feeds byte streams, predicts each digest.
// Holds its own SHA-256 predictor in a small scoreboard class; needs only the hasher RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam int ITEM_TARGET  = 380;

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int LEN_OFFSET = 56;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_slice_type;

   typedef logic [7:0] message_bytes_type[$];

   class digest_scoreboard;
      logic [31:0] chain [0:7];
      logic [7:0]  block_bytes [0:63];
      logic [63:0] byte_total;
      digest_slice_type pending[$];
      int errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
         for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
         byte_total = 64'd0;
      endfunction

      function logic [31:0] ror(input logic [31:0] x, input int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [0:63];
         logic [31:0] v [0:7];
         logic [31:0] t1, t2, ch, maj;
         for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
                   (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int i = 0; i < 64; i++) begin
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1  = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch +
                  ROUND_K[i] + w[i];
            t2  = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + maj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      function void absorb(input logic [7:0] b);
         block_bytes[byte_total[5:0]] = b;
         byte_total = byte_total + 64'd1;
         if (byte_total[5:0] == 6'd0) compress();
      endfunction

      // Note one accepted input item; an end item queues the four digest words.
      function void note_item(input logic [7:0] data, input logic present, input logic eom);
         logic [63:0] bit_len;
         digest_slice_type s;
         if (present) absorb(data);
         if (!eom) return;
         bit_len = byte_total << 3;
         absorb(PAD_MARK);
         while (byte_total[5:0] != LEN_OFFSET[5:0]) absorb(8'h00);
         for (int k = 7; k >= 0; k--) absorb(bit_len[8*k +: 8]);
         for (int k = 0; k < 4; k++) begin
            s.word  = {chain[2*k], chain[2*k+1]};
            s.index = k[1:0];
            s.last  = (k == 3);
            pending.push_back(s);
         end
         restart();
      endfunction

      function void check_result(input logic [63:0] word, input logic [1:0] index,
                                 input logic last);
         digest_slice_type s;
         if (pending.size() == 0) begin
            $display("%0t: unexpected digest word, expected none, got %h idx %0d last %0b",
                     $time, word, index, last);
            errors++;
            return;
         end
         s = pending.pop_front();
         if (word !== s.word) begin
            $display("%0t: digest word mismatch, expected %h, got %h", $time, s.word, word);
            errors++;
         end
         if (index !== s.index) begin
            $display("%0t: word index mismatch, expected %0d, got %0d", $time, s.index, index);
            errors++;
         end
         if (last !== s.last) begin
            $display("%0t: last flag mismatch, expected %0b, got %0b", $time, s.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] byte_present
   logic        req_tlast = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [63:0] digest_word
   logic [1:0]  rsp_tuser;           // [1:0] word_index
   logic        rsp_tlast;           // last_word

   digest_scoreboard board = new();
   bit steady = 1'b0;
   int hold_requests = 0;
   int items_sent = 0;

   sha256_message_hasher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic offer_item(input logic [7:0] data, input logic present, input logic eom);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(data, present, eom);
      items_sent++;
   endtask

   // Send one message; end either rides on the last byte or comes as a bare end item.
   task automatic send_message(input message_bytes_type msg, input bit merge_end,
                               input bit noisy);
      int n;
      n = msg.size();
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 99) < 4)
            offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         offer_item(msg[i], 1'b1, merge_end && (i == n - 1));
      end
      if (!merge_end || n == 0)
         offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Result side: check accepted words, then choose next ready.
   initial begin
      int hold_left;
      int holds_done;
      hold_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("** sha256_message_hasher_top: FAILED **");
      $finish;
   end

   initial begin
      message_bytes_type msg;
      int msg_count;
      int pick;
      int len;
      msg_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message straight out of reset, then again after an ignored item.
      offer_item(8'h3c, 1'b0, 1'b1);
      offer_item(8'hff, 1'b0, 1'b0);
      offer_item(8'h00, 1'b0, 1'b1);
      send_message('{8'h61, 8'h62, 8'h63}, 1'b1, 1'b0);
      send_message('{8'h00}, 1'b1, 1'b0);
      send_message('{8'hff}, 1'b1, 1'b0);
      send_message('{8'h80, 8'h7f, 8'h01, 8'hfe}, 1'b0, 1'b0);
      offer_item(8'h55, 1'b1, 1'b0);
      offer_item(8'haa, 1'b0, 1'b0);
      offer_item(8'hff, 1'b0, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= 150 && items_sent < 240);
         pick = $urandom_range(0, 99);
         if (pick < 65)
            len = $urandom_range(0, 12);
         else if (pick < 90)
            len = $urandom_range(52, 66);
         else
            len = $urandom_range(110, 130);
         // trim the last message so the run stays near the item target
         if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
         msg = {};
         for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
         send_message(msg, 1'($urandom_range(0, 1)), 1'b1);
         msg_count++;
         // Stall the result side so the block backs up into the input.
         if (msg_count == 2) hold_requests <= hold_requests + 1;
         if (msg_count == 7) wait_drained();
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("** sha256_message_hasher_top: PASSED **");
      end else begin
         $display("** sha256_message_hasher_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sha256_message_hasher_top.f -----
+incdir+sv
sv/sha_pkg.sv
sv/sha_core.sv
sv/sha256_message_hasher_top.sv
sv/sha_checker.sv
test/testbench.sv
